/* rtl/core/ure_pkg.sv */
// Shared types and constants for the ultrasonic echo ranger.
package ure_pkg;

    localparam int CNT_W   = 20;
    localparam int HIGH_W  = 16;
    localparam int TRIG_W  = 8;
    localparam int SCALE_W = 16;
    localparam int DIST_W  = 24;
    localparam int CFG_W   = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [HIGH_W-1:0] HIGH_MAX = '1;

    // Measurement phases.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_MEAS = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_SCALE = 2'd2;

    localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST  = 8'd15;
    localparam logic [CNT_W-1:0]   TIMEOUT_TICKS_RST  = 20'd30000;
    localparam logic [SCALE_W-1:0] DISTANCE_SCALE_RST = 16'd1114;

    typedef struct packed {
        logic [TRIG_W-1:0]  trigger_ticks;
        logic [CNT_W-1:0]   timeout_ticks;
        logic [SCALE_W-1:0] distance_scale;
    } cfg_t;

    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              done_res;
        logic              timed_out;
        logic [HIGH_W-1:0] echo_ticks;
        logic [DIST_W-1:0] distance_q8;
    } res_t;

endpackage

/* rtl/core/ure_if.sv */
// Valid/ready channel interfaces for tick input and result output.
interface ure_in_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo_level;

    modport source (output valid, output start_req, output echo_level, input ready);
    modport sink   (input valid, input start_req, input echo_level, output ready);
endinterface

interface ure_out_if import ure_pkg::*;;
    logic              valid;
    logic              ready;
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic              timed_out;
    logic [HIGH_W-1:0] echo_ticks;
    logic [DIST_W-1:0] distance_q8;

    modport source (output valid, output trigger_level, output busy_res, output done_res,
                    output timed_out, output echo_ticks, output distance_q8, input ready);
    modport sink   (input valid, input trigger_level, input busy_res, input done_res,
                    input timed_out, input echo_ticks, input distance_q8, output ready);
endinterface

/* rtl/core/ure_cfg.sv */
// Configuration register file.
module ure_cfg
    import ure_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_ticks  <= TRIGGER_TICKS_RST;
            cfg_reg.timeout_ticks  <= TIMEOUT_TICKS_RST;
            cfg_reg.distance_scale <= DISTANCE_SCALE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TRIGGER_TICKS:  cfg_reg.trigger_ticks  <= cfg_wdata[TRIG_W-1:0];
                CFG_TIMEOUT_TICKS:  cfg_reg.timeout_ticks  <= cfg_wdata[CNT_W-1:0];
                CFG_DISTANCE_SCALE: cfg_reg.distance_scale <= cfg_wdata[SCALE_W-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/ure_step.sv */
// Measurement state machine: one tick of trigger, echo wait and echo timing.
module ure_step
    import ure_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step_en,
    input  logic start_req,
    input  logic echo_level,
    input  cfg_t cfg,
    output res_t res
);

    logic [1:0]        phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next, cnt_inc;
    logic [HIGH_W-1:0] high_reg, high_next;
    logic              echo_prev_reg;
    logic              rise, fall;
    logic [HIGH_W+SCALE_W-1:0] product;

    assign rise    = echo_level & ~echo_prev_reg;
    assign fall    = ~echo_level & echo_prev_reg;
    assign cnt_inc = (cnt_reg == CNT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    assign product = high_reg * cfg.distance_scale;

    always_comb
    begin
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        high_next       = high_reg;
        res.done_res    = 1'b0;
        res.timed_out   = 1'b0;
        res.echo_ticks  = '0;
        res.distance_q8 = '0;
        unique case (phase_reg) inside
            PH_IDLE:
            begin
                if (start_req)
                begin
                    phase_next = PH_TRIG;
                    cnt_next   = CNT_W'(1);
                    high_next  = '0;
                end
            end
            PH_TRIG:
            begin
                if (cnt_reg >= {{(CNT_W-TRIG_W){1'b0}}, cfg.trigger_ticks})
                begin
                    phase_next = PH_WAIT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_inc;
                end
            end
            PH_WAIT, PH_MEAS:
            begin
                cnt_next = cnt_inc;
                // A falling edge beats the timeout on the same tick.
                if (phase_reg == PH_MEAS && fall)
                begin
                    res.done_res    = 1'b1;
                    res.echo_ticks  = high_reg;
                    res.distance_q8 = product[HIGH_W+SCALE_W-1:8];
                    phase_next      = PH_IDLE;
                    cnt_next        = '0;
                end
                else if (cnt_inc >= cfg.timeout_ticks)
                begin
                    res.timed_out = 1'b1;
                    phase_next    = PH_IDLE;
                    cnt_next      = '0;
                end
                else if (phase_reg == PH_WAIT)
                begin
                    if (rise)
                    begin
                        phase_next = PH_MEAS;
                        high_next  = HIGH_W'(1);
                    end
                end
                else if (echo_level && high_reg != HIGH_MAX)
                begin
                    high_next = high_reg + 1'b1;
                end
            end
        endcase
        res.trigger_level = (phase_next == PH_TRIG);
        res.busy_res      = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cnt_reg       <= '0;
            high_reg      <= '0;
            echo_prev_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            high_reg      <= high_next;
            echo_prev_reg <= echo_level;
        end
    end

endmodule

/* rtl/core/ultrasonic_echo_ranger.sv */
// Ultrasonic ranger top level: input register, tick state machine, result register.
//
//   channel   direction  handshake      payload
//   tick      in         valid/ready    start_req, echo_level
//   result    out        valid/ready    trigger_level, busy_res, done_res, timed_out,
//                                       echo_ticks, distance_q8
//   cfg       in         write enable   cfg_index, cfg_wdata
//
// Each tick transaction yields one result transaction via the input and result registers.
// One tick per cycle is sustained if result is ready; the input and result registers each
// hold one transaction, and the tick state machine advances as a tick moves between them.
// Reset clears measurement state and both valid flags and loads the configuration defaults.
// A stall on the result side backs up into the input register and then the tick channel.
module ultrasonic_echo_ranger
    import ure_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    ure_in_if.sink               tick,
    ure_out_if.source            result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t cfg;
    res_t res;
    res_t res_reg;
    logic in_valid_reg, out_valid_reg;
    logic start_reg, echo_reg;
    logic advance;

    // The result register can take a new value when empty or being drained.
    assign advance    = ~out_valid_reg | result.ready;
    assign tick.ready = ~in_valid_reg | advance;

    ure_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ure_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .step_en    (in_valid_reg & advance),
        .start_req  (start_reg),
        .echo_level (echo_reg),
        .cfg        (cfg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick.ready)
            begin
                in_valid_reg <= tick.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            start_reg <= tick.start_req;
            echo_reg  <= tick.echo_level;
        end
        if (in_valid_reg && advance)
        begin
            res_reg <= res;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.trigger_level = res_reg.trigger_level;
    assign result.busy_res      = res_reg.busy_res;
    assign result.done_res      = res_reg.done_res;
    assign result.timed_out     = res_reg.timed_out;
    assign result.echo_ticks    = res_reg.echo_ticks;
    assign result.distance_q8   = res_reg.distance_q8;

endmodule

/* rtl/core/ure_checker.sv */
// Port-level checks for the ultrasonic echo ranger, bound to the top level.
module ure_port_checker
    import ure_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              r_valid,
    input logic              r_ready,
    input logic              r_trigger,
    input logic              r_busy,
    input logic              r_done,
    input logic              r_tmo,
    input logic [HIGH_W-1:0] r_ticks,
    input logic [DIST_W-1:0] r_dist
);

    // A measurement ends by exactly one cause and leaves the block idle.
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && (r_done || r_tmo) |-> !r_busy && !r_trigger && !(r_done && r_tmo))
        else $error("measurement end not exclusive or not idle");

    // The trigger is only driven during a measurement.
    a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && r_trigger |-> r_busy)
        else $error("trigger driven while idle");

    // Count and distance carry meaning only with done.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_done |-> r_ticks == '0 && r_dist == '0)
        else $error("count or distance nonzero without done");

    // A stalled result transaction stays valid and holds its done, busy, count and distance.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid && !r_ready |=> r_valid && $stable(r_done) && $stable(r_ticks)
            && $stable(r_dist) && $stable(r_busy))
        else $error("stalled result changed");

endmodule

bind ultrasonic_echo_ranger ure_port_checker u_ure_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .r_valid   (result.valid),
    .r_ready   (result.ready),
    .r_trigger (result.trigger_level),
    .r_busy    (result.busy_res),
    .r_done    (result.done_res),
    .r_tmo     (result.timed_out),
    .r_ticks   (result.echo_ticks),
    .r_dist    (result.distance_q8)
);
